// ===== rtl/core/ellipse_span_generator_macros.svh =====
// assertion macros shared by the ellipse span generator rtl
// needs a clock named clk and a synchronous reset named rst in the using module
`ifndef ELLIPSE_SPAN_GENERATOR_MACROS_SVH
`define ELLIPSE_SPAN_GENERATOR_MACROS_SVH

// same-cycle implication, muted during reset
`define ESG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, muted during reset
`define ESG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/esg_pkg.sv =====
// shared types, constants and step functions for the ellipse span generator
// no dependencies
`default_nettype none

package esg_pkg;

  localparam int RAD_BITS    = 5;
  localparam int COORD_BITS  = 12;
  localparam int SPAN_BITS   = COORD_BITS + 1;
  localparam int DY_BITS     = RAD_BITS + 1;
  localparam int SQ_BITS     = 2 * RAD_BITS;
  localparam int N_BITS      = 2 * SQ_BITS;
  localparam int ROOT_BITS   = SQ_BITS;
  localparam int REM_BITS    = ROOT_BITS + 1;
  localparam int SQRT_STAGES = 5;
  localparam int DIV_STAGES  = 5;
  localparam int SQRT_STEPS  = ROOT_BITS / SQRT_STAGES;
  localparam int DIV_STEPS   = ROOT_BITS / DIV_STAGES;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // side data that travels with each span down the pipe
  typedef struct packed {
    logic [SPAN_BITS-1:0]  row;
    logic [COORD_BITS-1:0] cx;
    logic [RAD_BITS-1:0]   rx;
    logic [RAD_BITS-1:0]   ry;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [7:0]            alpha;
    logic                  last;
  } span_ctx_t;

  typedef struct packed {
    logic [N_BITS-1:0]    n;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } sqrt_state_t;

  typedef struct packed {
    logic [ROOT_BITS-1:0] q;
    logic [RAD_BITS-1:0]  rem;
  } div_state_t;

  // one digit of the floor square root, two radicand bits consumed
  function automatic sqrt_state_t sqrt_step(sqrt_state_t s);
    logic [REM_BITS+1:0] acc;
    logic [REM_BITS+1:0] trial;
    sqrt_state_t         r;
    acc   = {s.rem, s.n[N_BITS-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.n   = {s.n[N_BITS-3:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = REM_BITS'(acc - trial);
      r.root = {s.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      r.rem  = acc[REM_BITS-1:0];
      r.root = {s.root[ROOT_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit of a restoring division by the vertical radius
  function automatic div_state_t div_step(div_state_t s, logic [RAD_BITS-1:0] d);
    logic [RAD_BITS:0] acc;
    div_state_t        r;
    acc = {s.rem, s.q[ROOT_BITS-1]};
    if (acc >= {1'b0, d}) begin
      r.rem = RAD_BITS'(acc - {1'b0, d});
      r.q   = {s.q[ROOT_BITS-2:0], 1'b1};
    end else begin
      r.rem = acc[RAD_BITS-1:0];
      r.q   = {s.q[ROOT_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/esg_row_seq.sv =====
// row sequencer: holds one shape and issues one row offset per pipeline advance
// depends on esg_pkg
`default_nettype none

module esg_row_seq (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           adv,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [esg_pkg::COORD_BITS-1:0] center_x,
  input  wire logic [esg_pkg::COORD_BITS-1:0] center_y,
  input  wire logic [esg_pkg::RAD_BITS-1:0]   radius_x,
  input  wire logic [esg_pkg::RAD_BITS-1:0]   radius_y,
  input  wire logic [7:0]                     in_red,
  input  wire logic [7:0]                     in_green,
  input  wire logic [7:0]                     in_blue,
  input  wire logic [7:0]                     in_alpha,
  input  wire logic                           force_opaque,
  output logic                                seq_valid,
  output logic [esg_pkg::DY_BITS-1:0]         seq_dy,
  output esg_pkg::span_ctx_t                  seq_ctx
);

  logic                           busy;
  logic [esg_pkg::DY_BITS-1:0]    dy;
  logic [esg_pkg::COORD_BITS-1:0] cx;
  logic [esg_pkg::COORD_BITS-1:0] cy;
  logic [esg_pkg::RAD_BITS-1:0]   rx;
  logic [esg_pkg::RAD_BITS-1:0]   ry;
  logic [7:0]                     red, green, blue, alpha;
  logic                           at_last;
  esg_pkg::span_ctx_t             ctx_next;

  assign in_stall = busy;
  assign at_last  = (dy == {1'b0, ry});

  // span side data for the current row
  always_comb begin
    ctx_next.row   = {cy[esg_pkg::COORD_BITS-1], cy}
                   + {{(esg_pkg::SPAN_BITS-esg_pkg::DY_BITS){dy[esg_pkg::DY_BITS-1]}}, dy};
    ctx_next.cx    = cx;
    ctx_next.rx    = rx;
    ctx_next.ry    = ry;
    ctx_next.red   = red;
    ctx_next.green = green;
    ctx_next.blue  = blue;
    ctx_next.alpha = alpha;
    ctx_next.last  = at_last;
  end

  // busy flag (set on shape capture, cleared after the last row) and issued-row valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      seq_valid <= 1'b0;
    end else begin
      if (in_valid && !busy) begin
        busy <= 1'b1;
      end else if (busy && adv && at_last) begin
        busy <= 1'b0;
      end
      if (adv) begin
        seq_valid <= busy;
      end
    end
  end

  // shape payload, row offset and issued row
  always_ff @(posedge clk) begin
    if (in_valid && !busy) begin
      cx    <= center_x;
      cy    <= center_y;
      rx    <= radius_x;
      ry    <= radius_y;
      red   <= in_red;
      green <= in_green;
      blue  <= in_blue;
      alpha <= force_opaque ? esg_pkg::ALPHA_OPAQUE : in_alpha;
      dy    <= esg_pkg::DY_BITS'(-{1'b0, radius_y});
    end else if (busy && adv) begin
      dy <= dy + esg_pkg::DY_BITS'(1);
    end
    if (adv) begin
      seq_dy  <= dy;
      seq_ctx <= ctx_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/esg_isqrt_pipe.sv =====
// pipelined floor square root, two result bits per stage
// depends on esg_pkg
`default_nettype none

module esg_isqrt_pipe (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          in_valid,
  input  wire logic [esg_pkg::N_BITS-1:0]    in_n,
  input  wire esg_pkg::span_ctx_t            in_ctx,
  output logic                               out_valid,
  output logic [esg_pkg::ROOT_BITS-1:0]      out_root,
  output esg_pkg::span_ctx_t                 out_ctx
);

  logic                 vld [esg_pkg::SQRT_STAGES];
  esg_pkg::sqrt_state_t st  [esg_pkg::SQRT_STAGES];
  esg_pkg::span_ctx_t   ctx [esg_pkg::SQRT_STAGES];

  for (genvar g = 0; g < esg_pkg::SQRT_STAGES; g++) begin : g_stage
    logic                 vld_in;
    esg_pkg::sqrt_state_t st_in;
    esg_pkg::span_ctx_t   ctx_in;
    esg_pkg::sqrt_state_t st_next;

    // stage input, from the ports or the stage before
    if (g == 0) begin : g_head
      assign vld_in = in_valid;
      assign st_in  = '{n: in_n, rem: '0, root: '0};
      assign ctx_in = in_ctx;
    end else begin : g_link
      assign vld_in = vld[g-1];
      assign st_in  = st[g-1];
      assign ctx_in = ctx[g-1];
    end

    // this stage's digits
    always_comb begin
      st_next = st_in;
      for (int k = 0; k < esg_pkg::SQRT_STEPS; k++) begin
        st_next = esg_pkg::sqrt_step(st_next);
      end
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (adv) begin
        vld[g] <= vld_in;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (adv) begin
        st[g]  <= st_next;
        ctx[g] <= ctx_in;
      end
    end
  end

  assign out_valid = vld[esg_pkg::SQRT_STAGES-1];
  assign out_root  = st[esg_pkg::SQRT_STAGES-1].root;
  assign out_ctx   = ctx[esg_pkg::SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/esg_div_pipe.sv =====
// pipelined restoring division of the root by the vertical radius
// depends on esg_pkg
`default_nettype none

module esg_div_pipe (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          in_valid,
  input  wire logic [esg_pkg::ROOT_BITS-1:0] in_root,
  input  wire esg_pkg::span_ctx_t            in_ctx,
  output logic                               out_valid,
  output logic [esg_pkg::ROOT_BITS-1:0]      out_quot,
  output esg_pkg::span_ctx_t                 out_ctx
);

  logic                vld [esg_pkg::DIV_STAGES];
  esg_pkg::div_state_t st  [esg_pkg::DIV_STAGES];
  esg_pkg::span_ctx_t  ctx [esg_pkg::DIV_STAGES];

  for (genvar g = 0; g < esg_pkg::DIV_STAGES; g++) begin : g_stage
    logic                vld_in;
    esg_pkg::div_state_t st_in;
    esg_pkg::span_ctx_t  ctx_in;
    esg_pkg::div_state_t st_next;

    // stage input, from the ports or the stage before
    if (g == 0) begin : g_head
      assign vld_in = in_valid;
      assign st_in  = '{q: in_root, rem: '0};
      assign ctx_in = in_ctx;
    end else begin : g_link
      assign vld_in = vld[g-1];
      assign st_in  = st[g-1];
      assign ctx_in = ctx[g-1];
    end

    // this stage's quotient bits
    always_comb begin
      st_next = st_in;
      for (int k = 0; k < esg_pkg::DIV_STEPS; k++) begin
        st_next = esg_pkg::div_step(st_next, ctx_in.ry);
      end
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (adv) begin
        vld[g] <= vld_in;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (adv) begin
        st[g]  <= st_next;
        ctx[g] <= ctx_in;
      end
    end
  end

  assign out_valid = vld[esg_pkg::DIV_STAGES-1];
  assign out_quot  = st[esg_pkg::DIV_STAGES-1].q;
  assign out_ctx   = ctx[esg_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/ellipse_span_generator.sv =====
// ellipse span generator top level: sequencer, squaring stages, root and divide pipes
// depends on esg_pkg, esg_row_seq, esg_isqrt_pipe, esg_div_pipe and the macros header
//
//   channel   signals                                   direction
//   shape     in_valid/in_stall, center_*, radius_*,    in
//             in_red/green/blue/alpha
//   span      out_valid/out_stall, span_*, out_*,       out
//             last_span
//   config    cfg_write, cfg_data (force_opaque)        in
//
// a shape of vertical radius ry gives 2*ry+1 spans, one per cycle while the pipe
// advances (out_stall can hold it); a new shape is taken only once the last row of
// the previous one has been issued (the row sequencer sets this)
// the first span leaves through the sequencer, two squaring stages, five root
// stages, five divide stages and the output register
// reset (rst, synchronous) empties the pipe and sets force_opaque
// out_stall freezes every stage at once while a span is held at the output, so nothing is dropped or repeated
`default_nettype none
`include "ellipse_span_generator_macros.svh"

module ellipse_span_generator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic                            cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [esg_pkg::COORD_BITS-1:0] center_x,
  input  wire logic signed [esg_pkg::COORD_BITS-1:0] center_y,
  input  wire logic [esg_pkg::RAD_BITS-1:0]    radius_x,
  input  wire logic [esg_pkg::RAD_BITS-1:0]    radius_y,
  input  wire logic [7:0]                      in_red,
  input  wire logic [7:0]                      in_green,
  input  wire logic [7:0]                      in_blue,
  input  wire logic [7:0]                      in_alpha,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [esg_pkg::SPAN_BITS-1:0] span_row,
  output logic signed [esg_pkg::SPAN_BITS-1:0] span_left,
  output logic signed [esg_pkg::SPAN_BITS-1:0] span_right,
  output logic [7:0]                           out_red,
  output logic [7:0]                           out_green,
  output logic [7:0]                           out_blue,
  output logic [7:0]                           out_alpha,
  output logic                                 last_span
);

  logic                            force_opaque;
  logic                            adv;
  logic                            seq_valid;
  logic [esg_pkg::DY_BITS-1:0]     seq_dy;
  esg_pkg::span_ctx_t              seq_ctx;
  logic [esg_pkg::RAD_BITS-1:0]    ady;
  logic                            sq_valid;
  logic [esg_pkg::SQ_BITS-1:0]     sq_rx;
  logic [esg_pkg::SQ_BITS-1:0]     sq_diff;
  esg_pkg::span_ctx_t              sq_ctx;
  logic                            n_valid;
  logic [esg_pkg::N_BITS-1:0]      n_val;
  esg_pkg::span_ctx_t              n_ctx;
  logic                            rt_valid;
  logic [esg_pkg::ROOT_BITS-1:0]   rt_root;
  esg_pkg::span_ctx_t              rt_ctx;
  logic                            dv_valid;
  logic [esg_pkg::ROOT_BITS-1:0]   dv_quot;
  esg_pkg::span_ctx_t              dv_ctx;
  logic [esg_pkg::RAD_BITS-1:0]    half_w;
  logic [esg_pkg::SPAN_BITS-1:0]   cx_ext;
  logic [esg_pkg::SPAN_BITS-1:0]   hw_ext;

  // whole pipe moves unless a finished span is held at the output
  assign adv = !out_valid || !out_stall;

  // opaque mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      force_opaque <= 1'b1;
    end else if (cfg_write) begin
      force_opaque <= cfg_data;
    end
  end

  esg_row_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius_x     (radius_x),
    .radius_y     (radius_y),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_alpha     (in_alpha),
    .force_opaque (force_opaque),
    .seq_valid    (seq_valid),
    .seq_dy       (seq_dy),
    .seq_ctx      (seq_ctx)
  );

  // absolute row offset
  assign ady = seq_dy[esg_pkg::DY_BITS-1] ? esg_pkg::RAD_BITS'(-seq_dy)
                                          : seq_dy[esg_pkg::RAD_BITS-1:0];

  // squares rx*rx and ry*ry - dy*dy, then their product, with the stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      n_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      sq_valid  <= seq_valid;
      n_valid   <= sq_valid;
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rx   <= seq_ctx.rx * seq_ctx.rx;
      sq_diff <= (seq_ctx.ry * seq_ctx.ry) - (ady * ady);
      sq_ctx  <= seq_ctx;
      n_val   <= sq_rx * sq_diff;
      n_ctx   <= sq_ctx;
    end
  end

  esg_isqrt_pipe u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (n_valid),
    .in_n      (n_val),
    .in_ctx    (n_ctx),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_ctx   (rt_ctx)
  );

  esg_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (rt_valid),
    .in_root   (rt_root),
    .in_ctx    (rt_ctx),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_ctx   (dv_ctx)
  );

  // half width, flat shape takes the horizontal radius
  assign half_w = (dv_ctx.ry == '0) ? dv_ctx.rx : dv_quot[esg_pkg::RAD_BITS-1:0];
  assign cx_ext = {dv_ctx.cx[esg_pkg::COORD_BITS-1], dv_ctx.cx};
  assign hw_ext = {{(esg_pkg::SPAN_BITS-esg_pkg::RAD_BITS){1'b0}}, half_w};

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      span_row   <= dv_ctx.row;
      span_left  <= cx_ext - hw_ext;
      span_right <= cx_ext + hw_ext;
      out_red    <= dv_ctx.red;
      out_green  <= dv_ctx.green;
      out_blue   <= dv_ctx.blue;
      out_alpha  <= dv_ctx.alpha;
      last_span  <= dv_ctx.last;
    end
  end

  // checks
  `ESG_ASSERT_NOW(a_span_order, out_valid, span_left <= span_right, "span left beyond right")
  `ESG_ASSERT_NOW(a_span_sym, out_valid, span_left[0] == span_right[0], "span not symmetric")
  `ESG_ASSERT_NEXT(a_shape_busy, in_valid && !in_stall, in_stall, "shape taken but sequencer idle")

endmodule

`default_nettype wire

// ===== tb/esg_span_checker.sv =====
// span checker for the ellipse span generator: watches the shape, span and config channels,
// predicts the spans of each accepted shape request and compares them
// depends on esg_pkg for the field widths
`default_nettype none

module esg_span_checker (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write,
  input  wire logic cfg_data,
  input  wire logic in_valid,
  input  wire logic in_stall,
  input  wire logic signed [esg_pkg::COORD_BITS-1:0] center_x,
  input  wire logic signed [esg_pkg::COORD_BITS-1:0] center_y,
  input  wire logic [esg_pkg::RAD_BITS-1:0] radius_x,
  input  wire logic [esg_pkg::RAD_BITS-1:0] radius_y,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  input  wire logic [7:0] in_alpha,
  input  wire logic out_valid,
  input  wire logic out_stall,
  input  wire logic signed [esg_pkg::SPAN_BITS-1:0] span_row,
  input  wire logic signed [esg_pkg::SPAN_BITS-1:0] span_left,
  input  wire logic signed [esg_pkg::SPAN_BITS-1:0] span_right,
  input  wire logic [7:0] out_red,
  input  wire logic [7:0] out_green,
  input  wire logic [7:0] out_blue,
  input  wire logic [7:0] out_alpha,
  input  wire logic last_span,
  output int        fail_count,
  output int        pending_spans
);

  typedef struct packed {
    logic signed [esg_pkg::SPAN_BITS-1:0] row;
    logic signed [esg_pkg::SPAN_BITS-1:0] left;
    logic signed [esg_pkg::SPAN_BITS-1:0] right;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } span_t;

  span_t span_queue[$];
  logic  opaque_mode;

  // exact floor square root by linear search over a small range
  function automatic int floor_root(int n);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  // expected spans of one shape, top row first
  task automatic predict_spans();
    int    cx, cy, rx, ry, dy, half, ady;
    span_t s;
    cx = center_x;
    cy = center_y;
    rx = radius_x;
    ry = radius_y;
    for (dy = -ry; dy <= ry; dy++) begin
      ady = (dy < 0) ? -dy : dy;
      if (ry == 0) half = rx;
      else half = floor_root(rx * rx * (ry * ry - ady * ady)) / ry;
      s.row   = esg_pkg::SPAN_BITS'(cy + dy);
      s.left  = esg_pkg::SPAN_BITS'(cx - half);
      s.right = esg_pkg::SPAN_BITS'(cx + half);
      s.red   = in_red;
      s.green = in_green;
      s.blue  = in_blue;
      s.alpha = opaque_mode ? esg_pkg::ALPHA_OPAQUE : in_alpha;
      s.last  = (dy == ry);
      span_queue.push_back(s);
    end
  endtask

  // watch config, requests and spans
  always @(posedge clk) begin
    span_t got, want;
    if (rst) begin
      opaque_mode = 1'b1;
      span_queue.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) predict_spans();
      if (cfg_write) opaque_mode = cfg_data;
      if (out_valid && !out_stall) begin
        got = '{span_row, span_left, span_right, out_red, out_green, out_blue,
                out_alpha, last_span};
        if (span_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected span %p", got);
        end else begin
          want = span_queue.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("span mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
    pending_spans = span_queue.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb_ellipse_span_generator.sv =====
// testbench top for the ellipse span generator: clock, reset, shape stimulus,
// config phases, random stalls and verdict; depends on esg_pkg and esg_span_checker
`default_nettype none

module tb_ellipse_span_generator;

  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [esg_pkg::COORD_BITS-1:0] center_x = '0, center_y = '0;
  logic [esg_pkg::RAD_BITS-1:0] radius_x = '0, radius_y = '0;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [esg_pkg::SPAN_BITS-1:0] span_row, span_left, span_right;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  logic last_span;
  int   fail_count, pending_spans;
  int   idle_cycles = 0;
  bit   hold_off = 1'b0;

  always #5 clk = ~clk;

  ellipse_span_generator u_top (.*);

  esg_span_checker u_checker (.*);

  // watchdog on cycles with no accepted request or span
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ellipse_span_generator verification failed");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else case ($urandom_range(0, 3))
      0: out_stall <= ($urandom_range(0, 9) < 7);
      1: out_stall <= 1'b0;
      default: out_stall <= ($urandom_range(0, 9) < 2);
    endcase
  end

  initial begin
    @(posedge clk);
    repeat (3000) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // present one shape request and wait for it to be taken
  task automatic send_shape(int cx, int cy, int rx, int ry, int r, int g, int b, int a);
    @(negedge clk);
    in_valid <= 1'b1;
    center_x <= esg_pkg::COORD_BITS'(cx);
    center_y <= esg_pkg::COORD_BITS'(cy);
    radius_x <= esg_pkg::RAD_BITS'(rx);
    radius_y <= esg_pkg::RAD_BITS'(ry);
    in_red <= 8'(r); in_green <= 8'(g); in_blue <= 8'(b); in_alpha <= 8'(a);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // wait for all spans, then let the pipe settle before a register write
  task automatic drain_and_write(logic value);
    pause_sender(0);
    while (pending_spans != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_shapes(int count);
    int burst, rx, ry;
    burst = 0;
    repeat (count) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 20));
      end
      burst--;
      // mostly small shapes so the run stays short
      ry = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
      rx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8);
      send_shape($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048, rx, ry,
                 $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed shapes at reset mode (opaque)
    send_shape(0, 0, 0, 0, 8'h12, 8'h34, 8'h56, 8'h78);
    send_shape(100, -50, 7, 0, 255, 0, 255, 0);
    send_shape(-2048, -2048, 31, 31, 0, 255, 0, 255);
    send_shape(2047, 2047, 31, 31, 255, 255, 255, 255);
    send_shape(10, 20, 0, 5, 1, 2, 4, 8);
    send_shape(-1, 1, 5, 5, 128, 64, 32, 16);
    send_shape(300, 300, 31, 1, 170, 85, 170, 85);
    send_shape(-300, 5, 1, 31, 85, 170, 85, 170);

    drain_and_write(1'b0);
    send_shape(2047, -2048, 31, 0, 255, 255, 255, 0);
    send_shape(-2048, 2047, 0, 31, 0, 0, 0, 255);
    send_shape(42, -42, 3, 2, 9, 9, 9, 77);
    random_shapes(230);

    drain_and_write(1'b1);
    random_shapes(230);

    pause_sender(0);
    while (pending_spans != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("ellipse_span_generator verification clean");
    else $display("ellipse_span_generator verification failed");
    $finish;
  end

endmodule

`default_nettype wire
